/* rtl/core/dnfcm_pkg.sv */
package dnfcm_pkg;

    // field widths
    localparam int CODE_W         = 4;
    localparam int COLOR_W        = 8;
    localparam int POS_W          = 18;
    localparam int FRAME_PIXELS_W = 19;
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = 64;
    localparam int RGB565_W       = 16;

    // palette layout
    localparam int PAL_ENTRIES  = 16;
    localparam int PAL_PER_WORD = 4;

    // frame length after reset
    localparam int FRAME_PIXELS_RST = 230400;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PAL_A        = 3'd0,
        CFG_PAL_B        = 3'd1,
        CFG_PAL_C        = 3'd2,
        CFG_PAL_D        = 3'd3,
        CFG_FRAME_PIXELS = 3'd4
    } t_cfg_idx;

    // input word
    typedef struct packed {
        logic [CODE_W-1:0] pixel_code;
        logic              delta_frame;
    } t_in_word;

    // output word
    typedef struct packed {
        logic [COLOR_W-1:0] color;
        logic [POS_W-1:0]   pixel_position;
        logic               frame_last;
    } t_out_word;

    // per-pixel control carried from the sequencer into the update stage
    typedef struct packed {
        t_in_word word;
        logic     last;
        logic     filled;
    } t_tag;

    // color lookup, one rgb332 byte per palette entry
    typedef logic [PAL_ENTRIES-1:0][COLOR_W-1:0] t_clut;

    // rgb565 -> rgb332: r[15:13] g[10:8] b[4:3]
    function automatic logic [COLOR_W-1:0] rgb565_to_332(input logic [RGB565_W-1:0] c);
        return {c[15:13], c[10:8], c[4:3]};
    endfunction

endpackage

/* rtl/core/dnfcm_ram.sv */
module dnfcm_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 262144
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // one write port, one registered read port, read returns old data on collision
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/core/dnfcm_cfg.sv */
module dnfcm_cfg #(
    parameter int MAX_PIXELS = 262144,
    parameter int LIM_W      = 19
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [dnfcm_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [dnfcm_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output dnfcm_pkg::t_clut                  o_clut,
    output logic [LIM_W-1:0]                  o_limit
);

    import dnfcm_pkg::*;

    localparam int          LIMIT_RST_I = (FRAME_PIXELS_RST > MAX_PIXELS) ?
                                          MAX_PIXELS : FRAME_PIXELS_RST;
    localparam logic [LIM_W-1:0] LIMIT_RST = LIMIT_RST_I[LIM_W-1:0];
    localparam logic [LIM_W-1:0] LIMIT_MAX = MAX_PIXELS[LIM_W-1:0];

    t_clut            r_clut, n_clut;
    logic [LIM_W-1:0] r_limit, n_limit;
    t_cfg_idx         w_idx;
    logic [LIM_W-1:0] fp_ext;

    assign w_idx  = t_cfg_idx'(i_cfg_idx);
    assign fp_ext = LIM_W'(i_cfg_data[FRAME_PIXELS_W-1:0]);

    // palette words are kept already reduced to rgb332; frame length clamped once
    always_comb begin
        n_clut  = r_clut;
        n_limit = r_limit;
        if (i_cfg_we) begin
            unique case (w_idx) inside
                CFG_PAL_A, CFG_PAL_B, CFG_PAL_C, CFG_PAL_D: begin
                    for (int k = 0; k < PAL_PER_WORD; k++) begin
                        n_clut[{i_cfg_idx[1:0], 2'(k)}] =
                            rgb565_to_332(i_cfg_data[k*RGB565_W +: RGB565_W]);
                    end
                end
                CFG_FRAME_PIXELS: begin
                    if (fp_ext == '0) begin
                        n_limit = LIM_W'(1);
                    end else if (fp_ext > LIMIT_MAX) begin
                        n_limit = LIMIT_MAX;
                    end else begin
                        n_limit = fp_ext;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clut  <= '0;
            r_limit <= LIMIT_RST;
        end else begin
            r_clut  <= n_clut;
            r_limit <= n_limit;
        end
    end

    assign o_clut  = r_clut;
    assign o_limit = r_limit;

endmodule

/* rtl/core/dnfcm_seq.sv */
module dnfcm_seq #(
    parameter int MAX_PIXELS = 262144,
    parameter int LIM_W      = 19
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_accept,
    input  dnfcm_pkg::t_in_word            i_word,
    input  logic [LIM_W-1:0]               i_limit,
    input  logic                           i_wr_en,
    input  logic [$clog2(MAX_PIXELS)-1:0]  i_wr_addr,
    output logic [$clog2(MAX_PIXELS)-1:0]  o_addr,
    output dnfcm_pkg::t_tag                o_tag
);

    import dnfcm_pkg::*;

    localparam int AW = $clog2(MAX_PIXELS);
    localparam int FW = $clog2(MAX_PIXELS + 1);

    logic [AW-1:0]    r_cnt, n_cnt;
    logic [FW-1:0]    r_fill, n_fill;
    logic [LIM_W-1:0] cnt_inc;
    logic             last;

    // end of frame when the next position reaches the limit
    assign cnt_inc = LIM_W'(r_cnt) + LIM_W'(1);
    assign last    = (cnt_inc >= i_limit);

    // pixel counter
    always_comb begin
        n_cnt = r_cnt;
        if (i_accept) begin
            n_cnt = last ? '0 : r_cnt + AW'(1);
        end
    end

    // written entries always form a prefix of the store, so a fill count
    // stands in for clearing it
    always_comb begin
        n_fill = r_fill;
        if (i_wr_en && (FW'(i_wr_addr) == r_fill)) begin
            n_fill = r_fill + FW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_fill <= '0;
        end else begin
            r_cnt  <= n_cnt;
            r_fill <= n_fill;
        end
    end

    assign o_addr        = r_cnt;
    assign o_tag.word    = i_word;
    assign o_tag.last    = last;
    assign o_tag.filled  = (FW'(r_cnt) < r_fill);

    // the counter never runs more than one entry past the written prefix
    a_cnt_in_prefix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (FW + 1)'(r_cnt) <= (FW + 1)'(r_fill) + (FW + 1)'(1))
        else $error("pixel counter ahead of written prefix");

    // the fill count is bounded by the store depth
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FW'(MAX_PIXELS))
        else $error("fill count beyond store depth");

    // a word marked last wraps the counter
    a_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept && last |=> r_cnt == '0)
        else $error("counter did not wrap after last pixel");

endmodule

/* rtl/core/dnfcm_rmw.sv */
module dnfcm_rmw #(
    parameter int MAX_PIXELS = 262144
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_accept,
    input  logic [$clog2(MAX_PIXELS)-1:0]  i_addr,
    input  dnfcm_pkg::t_tag                i_tag,
    input  logic [dnfcm_pkg::CODE_W-1:0]   i_rd_data,
    input  dnfcm_pkg::t_clut               i_clut,
    input  logic                           i_out_stall,
    output logic                           o_stall,
    output logic                           o_wr_en,
    output logic [$clog2(MAX_PIXELS)-1:0]  o_wr_addr,
    output logic [dnfcm_pkg::CODE_W-1:0]   o_wr_data,
    output logic                           o_out_valid,
    output dnfcm_pkg::t_out_word           o_out_word
);

    import dnfcm_pkg::*;

    localparam int AW = $clog2(MAX_PIXELS);

    logic              r_s1_vld;
    t_tag              r_s1_tag;
    logic [AW-1:0]     r_s1_addr;
    logic              r_fw_vld;
    logic [AW-1:0]     r_fw_addr;
    logic [CODE_W-1:0] r_fw_val;
    logic              r_out_vld;
    t_out_word         r_out_word;

    logic              adv;
    logic [CODE_W-1:0] prev;
    logic [CODE_W-1:0] value;
    logic              wr_en;

    // the update stage moves whenever the output register is free or being taken
    assign adv     = !r_out_vld || !i_out_stall;
    assign o_stall = r_s1_vld && !adv;

    // previous frame value: a write landing in the read cycle wins, an entry
    // outside the written prefix reads as zero
    always_comb begin
        if (r_fw_vld && (r_fw_addr == r_s1_addr)) begin
            prev = r_fw_val;
        end else if (r_s1_tag.filled) begin
            prev = i_rd_data;
        end else begin
            prev = '0;
        end
        value = r_s1_tag.word.delta_frame ? (r_s1_tag.word.pixel_code ^ prev)
                                          : r_s1_tag.word.pixel_code;
    end

    assign wr_en     = r_s1_vld && adv;
    assign o_wr_en   = wr_en;
    assign o_wr_addr = r_s1_addr;
    assign o_wr_data = value;

    // update stage control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_fw_vld <= 1'b0;
        end else begin
            if (i_accept) begin
                r_s1_vld <= 1'b1;
                r_fw_vld <= wr_en;
            end else if (adv) begin
                r_s1_vld <= 1'b0;
            end
        end
    end

    // update stage payload and forwarding of the write that meets the read
    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_s1_tag  <= i_tag;
            r_s1_addr <= i_addr;
            r_fw_addr <= r_s1_addr;
            r_fw_val  <= value;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            if (wr_en) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_out_word.color          <= i_clut[value];
            r_out_word.pixel_position <= POS_W'(r_s1_addr);
            r_out_word.frame_last     <= r_s1_tag.last;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_word  = r_out_word;

    // a new word enters only when the stage is empty or moving on
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept |-> (!r_s1_vld || adv))
        else $error("update stage overrun");

    // every write-back produces an output word
    a_write_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |=> r_out_vld)
        else $error("write-back without output word");

    // a write that meets a read is held for forwarding
    a_fw_capture: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept && wr_en |=> r_fw_vld && (r_fw_addr == $past(r_s1_addr)))
        else $error("forwarding register missed a colliding write");

endmodule

/* rtl/core/delta_nibble_frame_clut_mapper_top.sv */
// Xor-delta 4bpp frame decoder with palette lookup. Each input word carries one
// 4-bit pixel code and a delta-frame flag; a pixel counter walks the frame in
// raster order, in delta frames the code is xored with the same pixel's value
// from the previous frame, the new value goes back to the baseline memory, and
// the output word gives its palette color as rgb332, the pixel position and a
// last-pixel flag. One word per cycle is sustained while the output is not
// stalled: the baseline memory has one read and one write port, a pixel is read
// on acceptance and written back from the update stage, with forwarding when the
// same pixel is read in the write-back cycle (short frames). Accepted words pass
// through the update stage and the output register. The baseline memory is not
// swept after reset: a fill count marks the written prefix, and entries past it
// read as zero, so words are taken right out of reset. Palette and frame length
// are to be written while no pixels are in flight.
module delta_nibble_frame_clut_mapper_top #(
    parameter int MAX_PIXELS = 262144
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  dnfcm_pkg::t_in_word               i_in_word,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output dnfcm_pkg::t_out_word              o_out_word,
    input  logic                              i_cfg_we,
    input  logic [dnfcm_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [dnfcm_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    import dnfcm_pkg::*;

    localparam int AW    = $clog2(MAX_PIXELS);
    localparam int FW    = $clog2(MAX_PIXELS + 1);
    localparam int LIM_W = (FW > FRAME_PIXELS_W) ? FW : FRAME_PIXELS_W;

    t_clut             clut;
    logic [LIM_W-1:0]  limit;
    logic              accept;
    logic [AW-1:0]     rd_addr;
    t_tag              tag;
    logic [CODE_W-1:0] rd_data;
    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic [CODE_W-1:0] wr_data;

    assign accept = i_in_valid && !o_in_stall;

    // palette and frame length
    dnfcm_cfg #(
        .MAX_PIXELS (MAX_PIXELS),
        .LIM_W      (LIM_W)
    ) u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_clut     (clut),
        .o_limit    (limit)
    );

    // pixel counter and written-prefix tracking
    dnfcm_seq #(
        .MAX_PIXELS (MAX_PIXELS),
        .LIM_W      (LIM_W)
    ) u_seq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (accept),
        .i_word    (i_in_word),
        .i_limit   (limit),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .o_addr    (rd_addr),
        .o_tag     (tag)
    );

    // baseline memory, one nibble per pixel
    dnfcm_ram #(
        .WIDTH (CODE_W),
        .DEPTH (MAX_PIXELS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (wr_addr),
        .i_wdata (wr_data),
        .i_re    (accept),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    // xor update, write-back and color output
    dnfcm_rmw #(
        .MAX_PIXELS (MAX_PIXELS)
    ) u_rmw (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_addr      (rd_addr),
        .i_tag       (tag),
        .i_rd_data   (rd_data),
        .i_clut      (clut),
        .i_out_stall (i_out_stall),
        .o_stall     (o_in_stall),
        .o_wr_en     (wr_en),
        .o_wr_addr   (wr_addr),
        .o_wr_data   (wr_data),
        .o_out_valid (o_out_valid),
        .o_out_word  (o_out_word)
    );

endmodule
